/* rtl/core/tof_afp_pkg.sv */
// Package for the distance-sensor ASCII frame parser.
// Holds the parser phase type, register indexes, frame constants and the digit helper.
// No dependencies.
`default_nettype none

package tof_afp_pkg;

    typedef enum logic [1:0] {
        PHASE_HDR1 = 2'd0,
        PHASE_HDR2 = 2'd1,
        PHASE_BODY = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        REG_FIRST_HEADER  = 2'd0,
        REG_SECOND_HEADER = 2'd1,
        REG_END_MARKER    = 2'd2
    } reg_index_t;

    localparam logic [7:0]  FIRST_HEADER_RST  = 8'h64;
    localparam logic [7:0]  SECOND_HEADER_RST = 8'h3A;
    localparam logic [7:0]  END_MARKER_RST    = 8'h20;
    localparam logic [7:0]  DIGIT_BASE        = 8'd48;

    localparam logic [2:0]  POS_FIRST_DIGIT = 3'd2;
    localparam logic [2:0]  POS_LAST_DIGIT  = 3'd5;
    localparam logic [2:0]  POS_TERMINATOR  = 3'd6;
    localparam logic [2:0]  POS_SWALLOW     = 3'd7;

    localparam int          DIST_W = 18;

    typedef logic [DIST_W-1:0] dist_t;

    function automatic logic [7:0] digit_value(input logic [7:0] b);
        return (b < DIGIT_BASE) ? 8'd0 : 8'(b - DIGIT_BASE);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tof_ascii_frame_parser.sv */
// Top level of the distance-sensor ASCII frame parser.
// Depends on tof_afp_pkg.
//
// Usage:
//   Input channel (s_valid/s_ready/s_rx_byte) takes one UART byte per transfer.
//   Frame: first header, second header, four ASCII digits, terminator.
//   Digits are folded into a running decimal value (value*10 + digit) as they
//   arrive, so the terminator byte only has to load the result register.
//   Result channel (m_valid/m_ready/m_distance) carries one transfer per good
//   frame; m_valid rises the cycle after the terminator transfer.
//   Throughput: one byte per cycle; s_ready drops only while a result waits
//   and the receiver holds m_ready low, set by the single result register.
//   Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   indexes 0..2 select first header, second header and end marker, others
//   are ignored. Write only while idle.
//   Reset (aresetn low, synchronous) restores default header and end marker
//   values, returns the parser to waiting for the first header and drops
//   any pending result.
`default_nettype none

module tof_ascii_frame_parser (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic [7:0]                   s_rx_byte,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output tof_afp_pkg::dist_t                m_distance,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [7:0]                   cfg_data
);

    logic [7:0]          first_header_reg;
    logic [7:0]          second_header_reg;
    logic [7:0]          end_marker_reg;

    tof_afp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]          count_reg, count_next;
    tof_afp_pkg::dist_t  acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    tof_afp_pkg::dist_t  dist_reg;
    logic                emit;
    logic                s_xfer;
    logic [7:0]          digit;
    tof_afp_pkg::dist_t  acc_times_ten;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !m_valid_reg || m_ready;
    assign s_xfer     = s_valid && s_ready;
    assign m_valid    = m_valid_reg;
    assign m_distance = dist_reg;

    assign digit         = tof_afp_pkg::digit_value(s_rx_byte);
    assign acc_times_ten = (acc_reg << 3) + (acc_reg << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_header_reg  <= tof_afp_pkg::FIRST_HEADER_RST;
            second_header_reg <= tof_afp_pkg::SECOND_HEADER_RST;
            end_marker_reg    <= tof_afp_pkg::END_MARKER_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tof_afp_pkg::REG_FIRST_HEADER:  first_header_reg  <= cfg_data;
                tof_afp_pkg::REG_SECOND_HEADER: second_header_reg <= cfg_data;
                tof_afp_pkg::REG_END_MARKER:    end_marker_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        emit       = 1'b0;
        if (s_xfer) begin
            unique case (phase_reg)
                tof_afp_pkg::PHASE_HDR1: begin
                    if (s_rx_byte == first_header_reg) begin
                        phase_next = tof_afp_pkg::PHASE_HDR2;
                        count_next = 3'd1;
                    end else begin
                        phase_next = tof_afp_pkg::PHASE_HDR1;
                        count_next = 3'd0;
                    end
                end
                tof_afp_pkg::PHASE_HDR2: begin
                    if (s_rx_byte == second_header_reg) begin
                        phase_next = tof_afp_pkg::PHASE_BODY;
                        count_next = tof_afp_pkg::POS_FIRST_DIGIT;
                    end else begin
                        phase_next = tof_afp_pkg::PHASE_HDR1;
                        count_next = 3'd0;
                    end
                end
                tof_afp_pkg::PHASE_BODY: begin
                    if (count_reg == tof_afp_pkg::POS_FIRST_DIGIT) begin
                        acc_next = tof_afp_pkg::dist_t'(digit);
                    end else if (count_reg <= tof_afp_pkg::POS_LAST_DIGIT) begin
                        acc_next = acc_times_ten + tof_afp_pkg::dist_t'(digit);
                    end
                    if (count_reg == tof_afp_pkg::POS_TERMINATOR &&
                        s_rx_byte == end_marker_reg) begin
                        emit       = 1'b1;
                        phase_next = tof_afp_pkg::PHASE_HDR1;
                        count_next = 3'd0;
                    end else if (count_reg == tof_afp_pkg::POS_SWALLOW) begin
                        phase_next = tof_afp_pkg::PHASE_HDR1;
                        count_next = 3'd0;
                    end else begin
                        count_next = count_reg + 3'd1;
                    end
                end
                default: begin
                    phase_next = tof_afp_pkg::PHASE_HDR1;
                    count_next = 3'd0;
                end
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= tof_afp_pkg::PHASE_HDR1;
            count_reg   <= 3'd0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (emit) begin
            dist_reg <= acc_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tof_afp_checker.sv */
// Port-level checker for tof_ascii_frame_parser, with its bind statement.
// Depends on tof_afp_pkg and the top level's ports.
`default_nettype none

module tof_afp_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire tof_afp_pkg::dist_t m_distance,
    input wire logic               cfg_ready
);

    localparam tof_afp_pkg::dist_t DIST_MAX = tof_afp_pkg::dist_t'(229977);

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance))
        else $error("stalled result changed");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a waiting result");

    a_distance_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_distance <= DIST_MAX)
        else $error("distance out of range");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid |-> cfg_ready)
        else $error("configuration port not ready");

endmodule

bind tof_ascii_frame_parser tof_afp_checker u_tof_afp_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_distance (m_distance),
    .cfg_ready  (cfg_ready)
);

`default_nettype wire

/* sim/tof_ascii_frame_parser_test.sv */
// Self-checking testbench for tof_ascii_frame_parser: directed frames, then random
// frame traffic under several header and end-marker settings with random idling.
// Depends on tof_afp_pkg and the tof_ascii_frame_parser RTL.
module tof_ascii_frame_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT = 200000;
    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam logic [7:0] WRONG_TERM  = 8'h58;
    localparam logic [7:0] HDR1_RST    = tof_afp_pkg::FIRST_HEADER_RST;
    localparam logic [7:0] HDR2_RST    = tof_afp_pkg::SECOND_HEADER_RST;
    localparam logic [7:0] TERM_RST    = tof_afp_pkg::END_MARKER_RST;

    localparam logic [7:0] DIRECTED [25] = '{
        HDR1_RST, HDR2_RST, 8'hFF, 8'hFF, 8'hFF, 8'hFF, TERM_RST,
        HDR2_RST,
        HDR1_RST, HDR1_RST,
        HDR1_RST, HDR2_RST, 8'h00, 8'h39, 8'h30, 8'h35, WRONG_TERM,
        HDR1_RST,
        HDR1_RST, HDR2_RST, 8'h31, 8'h32, 8'h33, 8'h34, TERM_RST
    };

    class frame_tracker;
        logic [7:0]          hdr1;
        logic [7:0]          hdr2;
        logic [7:0]          end_mark;
        tof_afp_pkg::phase_t phase;
        logic [2:0]          count;
        logic [7:0]          digits [4];
        tof_afp_pkg::dist_t  expected_dist [$];
        int                  errors;

        function new();
            hdr1     = tof_afp_pkg::FIRST_HEADER_RST;
            hdr2     = tof_afp_pkg::SECOND_HEADER_RST;
            end_mark = tof_afp_pkg::END_MARKER_RST;
            errors   = 0;
            clear();
        endfunction

        function void clear();
            phase = tof_afp_pkg::PHASE_HDR1;
            count = 3'd0;
            foreach (digits[i]) digits[i] = 8'd0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                tof_afp_pkg::REG_FIRST_HEADER:  hdr1 = v;
                tof_afp_pkg::REG_SECOND_HEADER: hdr2 = v;
                tof_afp_pkg::REG_END_MARKER:    end_mark = v;
                default: ;
            endcase
        endfunction

        function void note_byte(logic [7:0] b);
            logic [2:0] pos;
            int         acc;
            pos = count;
            case (phase)
                tof_afp_pkg::PHASE_HDR1: begin
                    if (b == hdr1) begin
                        phase = tof_afp_pkg::PHASE_HDR2;
                        count = 3'd1;
                    end else begin
                        clear();
                    end
                end
                tof_afp_pkg::PHASE_HDR2: begin
                    if (b == hdr2) begin
                        phase = tof_afp_pkg::PHASE_BODY;
                        count = tof_afp_pkg::POS_FIRST_DIGIT;
                    end else begin
                        clear();
                    end
                end
                tof_afp_pkg::PHASE_BODY: begin
                    if (pos >= tof_afp_pkg::POS_FIRST_DIGIT &&
                        pos <= tof_afp_pkg::POS_LAST_DIGIT)
                        digits[2'(pos - tof_afp_pkg::POS_FIRST_DIGIT)] = b;
                    if (pos == tof_afp_pkg::POS_TERMINATOR && b == end_mark) begin
                        acc = 0;
                        foreach (digits[i])
                            acc = acc * 10 + ((digits[i] < tof_afp_pkg::DIGIT_BASE) ? 0 :
                                  int'(digits[i]) - int'(tof_afp_pkg::DIGIT_BASE));
                        expected_dist.push_back(tof_afp_pkg::dist_t'(acc));
                        phase = tof_afp_pkg::PHASE_HDR1;
                        count = 3'd0;
                    end else if (pos == tof_afp_pkg::POS_SWALLOW) begin
                        clear();
                    end else begin
                        count = pos + 3'd1;
                    end
                end
                default: clear();
            endcase
        endfunction

        function void check_distance(tof_afp_pkg::dist_t got);
            tof_afp_pkg::dist_t want;
            if (expected_dist.size() == 0) begin
                $error("distance: expected none, actual %0d", got);
                errors++;
            end else begin
                want = expected_dist.pop_front();
                if (want !== got) begin
                    $error("distance: expected %0d, actual %0d", want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_dist.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_rx_byte;
    logic               m_valid;
    logic               m_ready;
    tof_afp_pkg::dist_t m_distance;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [7:0]         cfg_data;

    frame_tracker tracker;
    int           cycles = 0;
    bit           idle_on = 1'b1;
    bit           stall_on = 1'b1;

    tof_ascii_frame_parser u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_distance (m_distance),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tof_ascii_frame_parser_test: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.check_distance(m_distance);
    end

    initial begin
        m_ready <= 1'b1;
        forever begin
            @(posedge aclk);
            if (stall_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        tracker.note_byte(b);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        tracker.set_reg(idx, v);
    endtask

    task automatic drain();
        while (tracker.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [7:0] h1, input logic [7:0] h2,
                                  input logic [7:0] em);
        drain();
        write_reg(REG_UNUSED, 8'($urandom));
        write_reg(tof_afp_pkg::REG_FIRST_HEADER, h1);
        write_reg(tof_afp_pkg::REG_SECOND_HEADER, h2);
        write_reg(tof_afp_pkg::REG_END_MARKER, em);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_traffic(input int n);
        int sent;
        int kind;
        int extra;
        sent = 0;
        while (sent < n) begin
            kind = $urandom_range(0, 9);
            if (kind <= 6) begin
                send_byte(tracker.hdr1);
                send_byte(tracker.hdr2);
                repeat (4) begin
                    send_byte($urandom_range(0, 1) ? 8'(48 + $urandom_range(0, 9))
                                                   : 8'($urandom));
                end
                if (kind <= 5) begin
                    send_byte(tracker.end_mark);
                    sent += 7;
                end else begin
                    send_byte(tracker.end_mark ^ 8'($urandom_range(1, 255)));
                    send_byte(8'($urandom));
                    sent += 8;
                end
            end else if (kind == 7) begin
                send_byte(tracker.hdr1);
                send_byte(8'($urandom));
                sent += 2;
            end else if (kind == 8) begin
                extra = $urandom_range(1, 3);
                repeat (extra) send_byte(8'($urandom));
                sent += extra;
            end else begin
                send_byte(tracker.hdr1);
                send_byte(tracker.hdr2);
                extra = $urandom_range(1, 3);
                repeat (extra) send_byte(8'($urandom));
                sent += 2 + extra;
            end
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        logic [7:0] h;
        tracker   = new();
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_rx_byte <= 8'd0;
        cfg_valid <= 1'b0;
        cfg_index <= tof_afp_pkg::REG_FIRST_HEADER;
        cfg_data  <= 8'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
        run_traffic(150);

        stall_on = $urandom_range(0, 3) != 0;
        idle_on  = $urandom_range(0, 3) != 0;
        apply_settings(8'h00, 8'h00, 8'h00);
        run_traffic(200);

        stall_on = $urandom_range(0, 3) != 0;
        idle_on  = $urandom_range(0, 3) != 0;
        apply_settings(8'hFF, 8'hFF, 8'hFF);
        run_traffic(200);

        stall_on = 1'b1;
        idle_on  = 1'b1;
        h = 8'($urandom);
        apply_settings(h, h, 8'($urandom));
        run_traffic(200);

        stall_on = $urandom_range(0, 3) != 0;
        idle_on  = $urandom_range(0, 3) != 0;
        apply_settings(8'($urandom), 8'($urandom), 8'($urandom));
        run_traffic(200);

        stall_on = 1'b0;
        idle_on  = 1'b0;
        apply_settings(HDR1_RST, HDR2_RST, TERM_RST);
        run_traffic(200);

        while (tracker.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("tof_ascii_frame_parser_test: done, clean");
        end else begin
            $display("tof_ascii_frame_parser_test: done, errors");
        end
        $finish;
    end

endmodule
